@@ src/bus_address_bitmap_allocator_core_assert.svh @@
// Assertion macros used by the checker file of the allocator.
`ifndef BUS_ADDRESS_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define BUS_ADDRESS_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// The property must hold at every rising clock edge outside reset.
`define BABA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define BABA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/baba_pkg.sv @@
package baba_pkg;

  localparam int MAP_WORDS   = 8;
  localparam int WORD_W      = 32;
  localparam int BIT_IDX_W   = $clog2(WORD_W);
  localparam int WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MAP_BITS    = MAP_WORDS * WORD_W;
  localparam int ADDR_W      = 8;
  localparam int LAST_USABLE = 247;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IN_USE    = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NONE_FREE = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  // Initial contents of one map word: every address free except the
  // broadcast address and the reserved addresses above the usable range.
  function automatic logic [WORD_W-1:0] init_word(input int w);
    logic [WORD_W-1:0] v;
    int a;
    v = '0;
    for (int b = 0; b < WORD_W; b++) begin
      a = w * WORD_W + b;
      v[b] = (a != 0) && (a <= LAST_USABLE);
    end
    return v;
  endfunction

endpackage

@@ src/baba_if.sv @@
interface baba_req_if;
  import baba_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output operation, output address, input ready);
  modport sink (input valid, input operation, input address, output ready);
endinterface

interface baba_rsp_if;
  import baba_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] granted_address;

  modport source (output valid, output status, output granted_address, input ready);
  modport sink (input valid, input status, input granted_address, output ready);
endinterface

@@ src/baba_ctrl.sv @@
module baba_ctrl
  import baba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/baba_dpath.sv @@
module baba_dpath
  import baba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        operation_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic [1:0]        status_o,
  output logic [ADDR_W-1:0] granted_address_o
);

  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

  logic [WORD_W-1:0]    map_q [MAP_WORDS];
  op_e                  op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [WIDX_W-1:0]    wi_q;
  status_e              res_status_q, res_status_d;
  logic [ADDR_W-1:0]    res_grant_q, res_grant_d;
  logic [1:0]           out_status_q;
  logic [ADDR_W-1:0]    out_grant_q;

  logic [WIDX_W-1:0]    addr_word;
  logic [BIT_IDX_W-1:0] addr_bit;
  logic                 addr_ok;
  logic [WIDX_W-1:0]    rd_idx;
  logic [WORD_W-1:0]    rd_word;
  logic [BIT_IDX_W-1:0] first_bit;
  logic                 done;
  logic                 wi_inc;
  logic                 wr_en;
  logic                 map_init;
  logic [WORD_W-1:0]    wr_data;

  assign addr_word = addr_q[BIT_IDX_W +: WIDX_W];
  assign addr_bit  = addr_q[BIT_IDX_W-1:0];
  assign addr_ok   = (int'(addr_q) <= LAST_USABLE) && (int'(addr_q) < MAP_BITS);
  assign rd_idx    = (op_q == OP_REQUEST) ? wi_q : addr_word;
  assign rd_word   = map_q[rd_idx];

  always_comb begin
    first_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (rd_word[i]) begin
        first_bit = BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    done         = 1'b0;
    wi_inc       = 1'b0;
    wr_en        = 1'b0;
    map_init     = 1'b0;
    wr_data      = rd_word;
    res_status_d = ST_OK;
    res_grant_d  = '0;
    case (op_q)
      OP_REQUEST: begin
        if (|rd_word) begin
          done        = 1'b1;
          res_grant_d = ADDR_W'({wi_q, first_bit});
          if (res_grant_d != '0) begin
            wr_en   = 1'b1;
            wr_data = rd_word & ~(WORD_W'(1) << first_bit);
          end
        end else if (wi_q == LAST_WORD) begin
          done         = 1'b1;
          res_status_d = ST_NONE_FREE;
        end else begin
          wi_inc = 1'b1;
        end
      end
      OP_ACQUIRE: begin
        done = 1'b1;
        if (!addr_ok) begin
          res_status_d = ST_INVALID;
        end else if (!rd_word[addr_bit]) begin
          res_status_d = ST_IN_USE;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_word & ~(WORD_W'(1) << addr_bit);
        end
      end
      OP_RELEASE: begin
        done = 1'b1;
        if (!addr_ok) begin
          res_status_d = ST_INVALID;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_word | (WORD_W'(1) << addr_bit);
        end
      end
      OP_INIT: begin
        done     = 1'b1;
        map_init = 1'b1;
      end
      default: done = 1'b1;
    endcase
  end

  assign sts_o.done = cmd_i.step && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_q[w] <= init_word(w);
      end
    end else if (cmd_i.step) begin
      if (map_init) begin
        for (int w = 0; w < MAP_WORDS; w++) begin
          map_q[w] <= init_word(w);
        end
      end else if (wr_en) begin
        map_q[rd_idx] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(operation_i);
      addr_q <= address_i;
      wi_q   <= '0;
    end else if (cmd_i.step && wi_inc) begin
      wi_q <= wi_q + WIDX_W'(1);
    end
    if (cmd_i.step && done) begin
      res_status_q <= res_status_d;
      res_grant_q  <= res_grant_d;
    end
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
    end
  end

  assign status_o          = out_status_q;
  assign granted_address_o = out_grant_q;

endmodule

@@ src/bus_address_bitmap_allocator_core.sv @@
// Channel  | Direction | Payload
// req_i    | in        | operation (2 bits), address (8 bits)
// rsp_o    | out       | status (2 bits), granted_address (8 bits)
//
// An item is taken, executed, and its result moved to the output register.
// Acquire, release and reinitialize pass the execute state once; a request scans the
// map one 32-bit word per cycle up to the first word with a free bit or the last word.
// Reset restores the map to its initial contents and empties the output register.
// A stalled result waits in the output register while the next item is accepted.
module bus_address_bitmap_allocator_core
  import baba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  baba_req_if.sink   req_i,
  baba_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  baba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  baba_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (req_i.operation),
    .address_i        (req_i.address),
    .status_o         (rsp_o.status),
    .granted_address_o(rsp_o.granted_address)
  );

endmodule

@@ src/baba_checker.sv @@
`include "bus_address_bitmap_allocator_core_assert.svh"

module baba_checker
  import baba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [1:0]        status_i,
  input logic [ADDR_W-1:0] granted_address_i
);

  `BABA_ASSERT(a_out_hold,
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(granted_address_i)),
    "Stalled result item changed")

  `BABA_ASSERT(a_busy_after_accept,
    (in_valid_i && in_ready_i) |=> !in_ready_i,
    "Input ready right after an accepted item")

  `BABA_ASSERT_NEVER(a_grant_range,
    out_valid_i && (int'(granted_address_i) > LAST_USABLE),
    "Granted address beyond the usable range")

  `BABA_ASSERT_NEVER(a_grant_status,
    out_valid_i && (granted_address_i != '0) && (status_i != ST_OK),
    "Nonzero granted address with an error status")

endmodule

bind bus_address_bitmap_allocator_core baba_checker u_baba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .granted_address_i(rsp_o.granted_address)
);

@@ verif/bus_address_bitmap_allocator_checker.sv @@
module bus_address_bitmap_allocator_checker
  import baba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic [1:0]        req_operation_i,
  input  logic [ADDR_W-1:0] req_address_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  logic [1:0]        rsp_status_i,
  input  logic [ADDR_W-1:0] rsp_granted_address_i,
  output int                error_count_o,
  output int                outstanding_o,
  output int                results_o,
  output int                none_free_o,
  output int                in_use_o,
  output int                invalid_o,
  output int                zero_grant_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] granted;
  } alloc_result_t;

  logic [WORD_W-1:0] free_words [MAP_WORDS];
  alloc_result_t     expected_results [$];

  function automatic void restore_map();
    int a;
    for (int w = 0; w < MAP_WORDS; w++) begin
      free_words[w] = '0;
    end
    for (a = 1; a <= LAST_USABLE && a < MAP_BITS; a++) begin
      free_words[a / WORD_W][a % WORD_W] = 1'b1;
    end
  endfunction

  function automatic alloc_result_t predict_allocation(op_e op, logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    bit            hit;
    int            lowest;
    int            word_idx;
    int            bit_idx;
    r.status  = ST_OK;
    r.granted = '0;
    hit       = 1'b0;
    word_idx  = int'(addr) / WORD_W;
    bit_idx   = int'(addr) % WORD_W;
    case (op)
      OP_REQUEST: begin
        for (int w = 0; w < MAP_WORDS; w++) begin
          if (!hit && free_words[w] != '0) begin
            lowest = 0;
            for (int b = WORD_W - 1; b >= 0; b--) begin
              if (free_words[w][b]) lowest = b;
            end
            hit       = 1'b1;
            r.granted = ADDR_W'(w * WORD_W + lowest);
            if (r.granted != '0) free_words[w][lowest] = 1'b0;
          end
        end
        if (!hit) r.status = ST_NONE_FREE;
      end
      OP_ACQUIRE, OP_RELEASE: begin
        if (int'(addr) > LAST_USABLE || int'(addr) >= MAP_BITS) begin
          r.status = ST_INVALID;
        end else if (op == OP_ACQUIRE) begin
          if (!free_words[word_idx][bit_idx]) r.status = ST_IN_USE;
          else free_words[word_idx][bit_idx] = 1'b0;
        end else begin
          free_words[word_idx][bit_idx] = 1'b1;
        end
      end
      default: begin
        restore_map();
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t predicted;
    alloc_result_t oldest;
    if (!rst_ni) begin
      restore_map();
      expected_results.delete();
      error_count_o = 0;
      outstanding_o = 0;
      results_o     = 0;
      none_free_o   = 0;
      in_use_o      = 0;
      invalid_o     = 0;
      zero_grant_o  = 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        predicted = predict_allocation(op_e'(req_operation_i), req_address_i);
        expected_results.push_back(predicted);
        if (op_e'(req_operation_i) == OP_REQUEST && predicted.status == ST_OK &&
            predicted.granted == '0) zero_grant_o++;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        results_o++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d address %0d",
                   $time, rsp_status_i, rsp_granted_address_i);
          error_count_o++;
        end else begin
          oldest = expected_results.pop_front();
          case (oldest.status)
            ST_NONE_FREE: none_free_o++;
            ST_IN_USE:    in_use_o++;
            ST_INVALID:   invalid_o++;
            default:      ;
          endcase
          if (rsp_status_i != oldest.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, oldest.status, rsp_status_i);
            error_count_o++;
          end
          if (rsp_granted_address_i != oldest.granted) begin
            $display("%0t: granted address mismatch: expected %0d, got %0d",
                     $time, oldest.granted, rsp_granted_address_i);
            error_count_o++;
          end
        end
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

@@ verif/bus_address_bitmap_allocator_core_tb.sv @@
module bus_address_bitmap_allocator_core_tb;
  import baba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  localparam int EP_EXHAUST = 0;
  localparam int EP_FILL    = 1;
  localparam int EP_DRAIN   = 2;
  localparam int EP_MIXED   = 3;

  localparam int RX_FREE = 0;
  localparam int RX_COIN = 1;
  localparam int RX_SLOW = 2;
  localparam int RX_HOLD = 3;

  logic clk_i;
  logic rst_ni;

  baba_req_if req_if ();
  baba_rsp_if rsp_if ();

  int error_count;
  int outstanding;
  int results;
  int none_free_count;
  int in_use_count;
  int invalid_count;
  int zero_grant_count;
  int burst_left;
  int items_sent;
  int cycles;

  bus_address_bitmap_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bus_address_bitmap_allocator_checker checker_i (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .req_valid_i           (req_if.valid),
    .req_ready_i           (req_if.ready),
    .req_operation_i       (req_if.operation),
    .req_address_i         (req_if.address),
    .rsp_valid_i           (rsp_if.valid),
    .rsp_ready_i           (rsp_if.ready),
    .rsp_status_i          (rsp_if.status),
    .rsp_granted_address_i (rsp_if.granted_address),
    .error_count_o         (error_count),
    .outstanding_o         (outstanding),
    .results_o             (results),
    .none_free_o           (none_free_count),
    .in_use_o              (in_use_count),
    .invalid_o             (invalid_count),
    .zero_grant_o          (zero_grant_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_item(op_e op, logic [ADDR_W-1:0] addr);
    if (burst_left == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_if.valid     = 1'b1;
    req_if.operation = op;
    req_if.address   = addr;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  function automatic op_e pick_operation(int kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      EP_EXHAUST: return (roll < 90) ? OP_REQUEST : OP_ACQUIRE;
      EP_FILL:    return (roll < 60) ? OP_REQUEST : (roll < 88) ? OP_ACQUIRE :
                         (roll < 99) ? OP_RELEASE : OP_INIT;
      EP_DRAIN:   return (roll < 10) ? OP_REQUEST : (roll < 25) ? OP_ACQUIRE :
                         (roll < 99) ? OP_RELEASE : OP_INIT;
      default:    return (roll < 33) ? OP_REQUEST : (roll < 63) ? OP_ACQUIRE :
                         (roll < 96) ? OP_RELEASE : OP_INIT;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address(op_e op);
    int roll;
    roll = $urandom_range(0, 9);
    if (op == OP_REQUEST || op == OP_INIT) return ADDR_W'($urandom_range(0, 255));
    case (roll)
      0:       return '0;
      1:       return ADDR_W'($urandom_range(LAST_USABLE + 1, 255));
      2, 3:    return ADDR_W'($urandom_range(1, 40));
      default: return ADDR_W'($urandom_range(0, LAST_USABLE));
    endcase
  endfunction

  initial begin
    int mode;
    int seg;
    int seg_left;
    rsp_if.ready = 1'b0;
    seg          = 0;
    seg_left     = 0;
    mode         = RX_FREE;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (seg_left == 0) begin
        seg++;
        if (seg == 3) begin
          mode     = RX_HOLD;
          seg_left = $urandom_range(250, 400);
        end else begin
          mode     = $urandom_range(RX_FREE, RX_SLOW);
          seg_left = $urandom_range(20, 120);
        end
      end
      seg_left--;
      case (mode)
        RX_FREE: rsp_if.ready = 1'b1;
        RX_COIN: rsp_if.ready = 1'($urandom_range(0, 1));
        RX_SLOW: rsp_if.ready = ($urandom_range(0, 3) == 0);
        default: rsp_if.ready = 1'b0;
      endcase
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run stopped after %0d cycles without finishing.", cycles);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int kind;
    int episode;
    int len;
    int random_sent;
    op_e op;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_REQUEST;
    req_if.address   = '0;
    burst_left       = 0;
    items_sent       = 0;
    random_sent      = 0;
    episode          = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(OP_REQUEST, 8'hff);
    send_item(OP_ACQUIRE, 8'd0);
    send_item(OP_ACQUIRE, 8'd247);
    send_item(OP_ACQUIRE, 8'd247);
    send_item(OP_ACQUIRE, 8'd248);
    send_item(OP_RELEASE, 8'd255);
    send_item(OP_RELEASE, 8'd0);
    send_item(OP_REQUEST, 8'd0);
    send_item(OP_REQUEST, 8'd0);
    send_item(OP_ACQUIRE, 8'd0);
    send_item(OP_REQUEST, 8'd0);
    send_item(OP_RELEASE, 8'd100);
    send_item(OP_ACQUIRE, 8'd31);
    send_item(OP_ACQUIRE, 8'd32);
    send_item(OP_ACQUIRE, 8'd63);
    send_item(OP_ACQUIRE, 8'd224);
    send_item(OP_RELEASE, 8'd128);
    send_item(OP_ACQUIRE, 8'haa);
    send_item(OP_ACQUIRE, 8'h55);
    send_item(OP_INIT, 8'haa);
    send_item(OP_REQUEST, 8'h55);
    send_item(OP_RELEASE, 8'd1);
    send_item(OP_REQUEST, 8'd0);

    while (random_sent < RANDOM_ITEMS) begin
      if (episode == 0) begin
        kind = EP_EXHAUST;
        len  = 280;
      end else begin
        kind = $urandom_range(0, 9) < 4 ? EP_FILL : $urandom_range(EP_EXHAUST, EP_MIXED);
        len  = $urandom_range(40, 200);
      end
      episode++;
      repeat (len) begin
        if (random_sent < RANDOM_ITEMS) begin
          op = pick_operation(kind);
          send_item(op, pick_address(op));
          random_sent++;
        end
      end
    end
    req_if.valid = 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d items over %0d random episodes; %0d results checked.",
             items_sent, episode, results);
    $display("Seen: %0d none free, %0d in use, %0d invalid, %0d grants of address zero.",
             none_free_count, in_use_count, invalid_count, zero_grant_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
